// File: hw/rtl/baro_pressure_temp_compensation_core_macros.svh
// Assertion macros used by the compensation core top level.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define BPTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define BPTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/baro_ptc_pkg.sv
// Types, widths and constants of the barometric compensation core.
`default_nettype none

package baro_ptc_pkg;

   localparam int RAW_W       = 24;
   localparam int CAL_W       = 16;
   localparam int TEMP_OUT_W  = 15;
   localparam int PRESS_OUT_W = 17;
   localparam int CSR_IDX_W   = 8;

   localparam int DT_W    = 25;
   localparam int PROD_W  = 42;
   localparam int SQDT_W  = 50;
   localparam int TEMP_W  = 20;
   localparam int T2_W    = 18;
   localparam int SQ_W    = 40;
   localparam int OFF_W   = 41;
   localparam int LO_W    = 21;
   localparam int HI_W    = OFF_W - LO_W;
   localparam int PP_W    = 45;
   localparam int DIFF_W  = 47;
   localparam int PRESS_W = DIFF_W - 15;

   localparam int UNIT_STAGES = 3;
   localparam int STAGES      = 3 * UNIT_STAGES;

   localparam int TEMP_REF    = 2000;
   localparam int COLD_OFFSET = 3500;
   localparam int TEMP_LOW    = -4000;
   localparam int TEMP_HIGH   = 8500;
   localparam int PRESS_LOW   = 1000;
   localparam int PRESS_HIGH  = 120000;

   localparam logic [CSR_IDX_W-1:0] CSR_C1 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_C2 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_C3 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_C4 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_C5 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_C6 = CSR_IDX_W'(5);

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_OUT_W-1:0] temperature_centi;
      logic [PRESS_OUT_W-1:0]       pressure_pa;
      logic                         clamped;
   } rsp_type;

   typedef struct packed {
      logic [CAL_W-1:0] c1;
      logic [CAL_W-1:0] c2;
      logic [CAL_W-1:0] c3;
      logic [CAL_W-1:0] c4;
      logic [CAL_W-1:0] c5;
      logic [CAL_W-1:0] c6;
   } calib_type;

   typedef struct packed {
      logic [UNIT_STAGES-1:0] load;
   } stage_ctl_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [TEMP_W-1:0] x;
      logic signed [TEMP_W-1:0] y;
      logic [T2_W-1:0]          t2;
      logic signed [OFF_W-1:0]  off;
      logic signed [OFF_W-1:0]  sens;
   } first_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [OFF_W-1:0]  off;
      logic signed [OFF_W-1:0]  sens;
   } corr_type;

endpackage

`default_nettype wire

// File: hw/rtl/baro_pressure_temp_compensation_core.sv
// Top level of the barometric pressure and temperature compensation core.
//
// Each item on the req channel carries one raw pressure and one raw temperature
// conversion. The rsp channel returns one item per request with the compensated
// temperature in hundredths of a degree, the pressure in pascal and a flag that
// is set when either value was saturated to its range.
// The six calibration words are written through the csr channel, which is always
// ready. They must only change while no item is in flight.
// The datapath is a nine-stage pipeline. A new item is accepted in every cycle
// unless a stalled rsp channel has filled the pipeline. The widest multiplier,
// sensitivity times raw pressure, is split in two partial products.
// Each stage holds its item until the next stage is free, so bubbles close up
// and a stalled rsp channel fills the pipeline before req_ready drops.
// Synchronous reset empties the pipeline and clears the calibration words.
`default_nettype none

`include "baro_pressure_temp_compensation_core_macros.svh"

module baro_pressure_temp_compensation_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  baro_ptc_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output baro_ptc_pkg::rsp_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [baro_ptc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [baro_ptc_pkg::CAL_W-1:0]      csr_data
);
   import baro_ptc_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] load;
   calib_type         calib_ff, calib_in;
   stage_ctl_type     front_ctl, second_ctl, press_ctl;
   first_type         first_data;
   corr_type          corr_data;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_comb begin
      calib_in = calib_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_C1: calib_in.c1 = csr_data;
            CSR_C2: calib_in.c2 = csr_data;
            CSR_C3: calib_in.c3 = csr_data;
            CSR_C4: calib_in.c4 = csr_data;
            CSR_C5: calib_in.c5 = csr_data;
            CSR_C6: calib_in.c6 = csr_data;
            default: calib_in = calib_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         calib_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         calib_ff <= calib_in;
      end
   end

   assign front_ctl.load  = load[UNIT_STAGES-1:0];
   assign second_ctl.load = load[2*UNIT_STAGES-1:UNIT_STAGES];
   assign press_ctl.load  = load[STAGES-1:2*UNIT_STAGES];

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign csr_ready = 1'b1;

   baro_ptc_front u_front (
      .clock      (clock),
      .ctl        (front_ctl),
      .calib      (calib_ff),
      .req_data   (req_data),
      .first_data (first_data)
   );

   baro_ptc_second u_second (
      .clock      (clock),
      .ctl        (second_ctl),
      .first_data (first_data),
      .corr_data  (corr_data)
   );

   baro_ptc_press u_press (
      .clock     (clock),
      .ctl       (press_ctl),
      .corr_data (corr_data),
      .rsp_data  (rsp_data)
   );

   `BPTC_ASSERT_SAME(a_press_range, clock, reset, rsp_valid, rsp_data.pressure_pa >= PRESS_OUT_W'(PRESS_LOW) && rsp_data.pressure_pa <= PRESS_OUT_W'(PRESS_HIGH), "Pressure result is outside its range.")
   `BPTC_ASSERT_SAME(a_temp_range, clock, reset, rsp_valid, rsp_data.temperature_centi >= TEMP_LOW && rsp_data.temperature_centi <= TEMP_HIGH, "Temperature result is outside its range.")
   `BPTC_ASSERT_SAME(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "Input stalled while the output stage is empty.")
   `BPTC_ASSERT_NEXT(a_csr_c1_write, clock, reset, csr_valid && csr_index == CSR_C1, calib_ff.c1 == $past(csr_data), "Calibration word one was not written.")

endmodule

`default_nettype wire

// File: hw/rtl/baro_ptc_front.sv
// First-order stages: temperature difference, calibration products and sums.
`default_nettype none

module baro_ptc_front (
   input  logic                    clock,
   input  baro_ptc_pkg::stage_ctl_type ctl,
   input  baro_ptc_pkg::calib_type calib,
   input  baro_ptc_pkg::req_type   req_data,
   output baro_ptc_pkg::first_type first_data
);
   import baro_ptc_pkg::*;

   logic [RAW_W-1:0]         d1_s1_ff, d1_s1_in;
   logic signed [DT_W-1:0]   dt_s1_ff, dt_s1_in;

   logic [RAW_W-1:0]         d1_s2_ff, d1_s2_in;
   logic signed [PROD_W-1:0] pt_s2_ff, pt_s2_in;
   logic signed [PROD_W-1:0] poff_s2_ff, poff_s2_in;
   logic signed [PROD_W-1:0] psens_s2_ff, psens_s2_in;
   logic signed [SQDT_W-1:0] pdd_s2_ff, pdd_s2_in;

   first_type                first_s3_ff, first_s3_in;

   always_comb begin
      d1_s1_in = req_data.raw_pressure;
      dt_s1_in = $signed({1'b0, req_data.raw_temperature}) - $signed({1'b0, calib.c5, 8'h00});
   end

   always_comb begin
      d1_s2_in    = d1_s1_ff;
      pt_s2_in    = dt_s1_ff * $signed({1'b0, calib.c6});
      poff_s2_in  = dt_s1_ff * $signed({1'b0, calib.c4});
      psens_s2_in = dt_s1_ff * $signed({1'b0, calib.c3});
      pdd_s2_in   = dt_s1_ff * dt_s1_ff;
   end

   always_comb begin
      first_s3_in.d1   = d1_s2_ff;
      first_s3_in.x    = TEMP_W'($signed(pt_s2_ff[PROD_W-1:23]));
      first_s3_in.temp = first_s3_in.x + TEMP_W'(TEMP_REF);
      first_s3_in.y    = first_s3_in.x + TEMP_W'(COLD_OFFSET);
      first_s3_in.t2   = pdd_s2_ff[48:31];
      first_s3_in.off  = OFF_W'($signed({1'b0, calib.c2, 16'h0000}))
                       + OFF_W'($signed(poff_s2_ff[PROD_W-1:7]));
      first_s3_in.sens = OFF_W'($signed({1'b0, calib.c1, 15'h0000}))
                       + OFF_W'($signed(psens_s2_ff[PROD_W-1:8]));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         d1_s1_ff <= d1_s1_in;
         dt_s1_ff <= dt_s1_in;
      end
      if (ctl.load[1]) begin
         d1_s2_ff    <= d1_s2_in;
         pt_s2_ff    <= pt_s2_in;
         poff_s2_ff  <= poff_s2_in;
         psens_s2_ff <= psens_s2_in;
         pdd_s2_ff   <= pdd_s2_in;
      end
      if (ctl.load[2]) begin
         first_s3_ff <= first_s3_in;
      end
   end

   assign first_data = first_s3_ff;

endmodule

`default_nettype wire

// File: hw/rtl/baro_ptc_second.sv
// Second-order stages: low-temperature corrections of temperature, offset and sensitivity.
`default_nettype none

module baro_ptc_second (
   input  logic                    clock,
   input  baro_ptc_pkg::stage_ctl_type ctl,
   input  baro_ptc_pkg::first_type first_data,
   output baro_ptc_pkg::corr_type  corr_data
);
   import baro_ptc_pkg::*;

   first_type                s4_ff, s4_in;
   logic [SQ_W-1:0]          a_s4_ff, a_s4_in;
   logic [SQ_W-1:0]          b_s4_ff, b_s4_in;
   logic                     lt20_s4_ff, lt20_s4_in;
   logic                     lt15_s4_ff, lt15_s4_in;

   logic [RAW_W-1:0]         d1_s5_ff, d1_s5_in;
   logic signed [TEMP_W-1:0] temp_s5_ff, temp_s5_in;
   logic signed [OFF_W-1:0]  off_s5_ff, off_s5_in;
   logic signed [OFF_W-1:0]  sens_s5_ff, sens_s5_in;
   logic [OFF_W-1:0]         off2_s5_ff, off2_s5_in;
   logic [OFF_W-1:0]         sens2_s5_ff, sens2_s5_in;

   logic [OFF_W-1:0]         a_w, b_w, a5, b7, b11;

   corr_type                 corr_s6_ff, corr_s6_in;

   always_comb begin
      s4_in      = first_data;
      a_s4_in    = SQ_W'(first_data.x * first_data.x);
      b_s4_in    = SQ_W'(first_data.y * first_data.y);
      lt20_s4_in = first_data.x[TEMP_W-1];
      lt15_s4_in = first_data.y[TEMP_W-1];
   end

   always_comb begin
      a_w  = OFF_W'(a_s4_ff);
      b_w  = OFF_W'(b_s4_ff);
      a5   = (a_w << 2) + a_w;
      b7   = (b_w << 3) - b_w;
      b11  = (b_w << 3) + (b_w << 1) + b_w;
      d1_s5_in   = s4_ff.d1;
      off_s5_in  = s4_ff.off;
      sens_s5_in = s4_ff.sens;
      if (lt20_s4_ff) begin
         temp_s5_in  = s4_ff.temp - TEMP_W'(s4_ff.t2);
         off2_s5_in  = (a5 >> 1) + (lt15_s4_ff ? b7 : '0);
         sens2_s5_in = (a5 >> 2) + (lt15_s4_ff ? (b11 >> 1) : '0);
      end else begin
         temp_s5_in  = s4_ff.temp;
         off2_s5_in  = '0;
         sens2_s5_in = '0;
      end
   end

   always_comb begin
      corr_s6_in.d1   = d1_s5_ff;
      corr_s6_in.temp = temp_s5_ff;
      corr_s6_in.off  = off_s5_ff - $signed(off2_s5_ff);
      corr_s6_in.sens = sens_s5_ff - $signed(sens2_s5_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s4_ff      <= s4_in;
         a_s4_ff    <= a_s4_in;
         b_s4_ff    <= b_s4_in;
         lt20_s4_ff <= lt20_s4_in;
         lt15_s4_ff <= lt15_s4_in;
      end
      if (ctl.load[1]) begin
         d1_s5_ff    <= d1_s5_in;
         temp_s5_ff  <= temp_s5_in;
         off_s5_ff   <= off_s5_in;
         sens_s5_ff  <= sens_s5_in;
         off2_s5_ff  <= off2_s5_in;
         sens2_s5_ff <= sens2_s5_in;
      end
      if (ctl.load[2]) begin
         corr_s6_ff <= corr_s6_in;
      end
   end

   assign corr_data = corr_s6_ff;

endmodule

`default_nettype wire

// File: hw/rtl/baro_ptc_press.sv
// Pressure stages: split sensitivity product, offset removal and output saturation.
`default_nettype none

module baro_ptc_press (
   input  logic                   clock,
   input  baro_ptc_pkg::stage_ctl_type ctl,
   input  baro_ptc_pkg::corr_type corr_data,
   output baro_ptc_pkg::rsp_type  rsp_data
);
   import baro_ptc_pkg::*;

   logic signed [TEMP_W-1:0]  temp_s7_ff, temp_s7_in;
   logic signed [OFF_W-1:0]   off_s7_ff, off_s7_in;
   logic [PP_W-1:0]           pplo_s7_ff, pplo_s7_in;
   logic signed [PP_W-1:0]    pphi_s7_ff, pphi_s7_in;

   logic signed [TEMP_W-1:0]  temp_s8_ff, temp_s8_in;
   logic signed [DIFF_W-1:0]  diff_s8_ff, diff_s8_in;

   logic signed [PRESS_W-1:0] press;
   rsp_type                   rsp_s9_ff, rsp_s9_in;

   always_comb begin
      temp_s7_in = corr_data.temp;
      off_s7_in  = corr_data.off;
      pplo_s7_in = corr_data.d1 * corr_data.sens[LO_W-1:0];
      pphi_s7_in = $signed({1'b0, corr_data.d1}) * $signed(corr_data.sens[OFF_W-1:LO_W]);
   end

   always_comb begin
      temp_s8_in = temp_s7_ff;
      diff_s8_in = DIFF_W'(pphi_s7_ff)
                 + DIFF_W'($signed({1'b0, pplo_s7_ff[PP_W-1:LO_W]}))
                 - DIFF_W'(off_s7_ff);
   end

   always_comb begin
      press             = $signed(diff_s8_ff[DIFF_W-1:15]);
      rsp_s9_in.clamped = 1'b0;
      if (temp_s8_ff < TEMP_LOW) begin
         rsp_s9_in.temperature_centi = TEMP_OUT_W'(TEMP_LOW);
         rsp_s9_in.clamped           = 1'b1;
      end else if (temp_s8_ff > TEMP_HIGH) begin
         rsp_s9_in.temperature_centi = TEMP_OUT_W'(TEMP_HIGH);
         rsp_s9_in.clamped           = 1'b1;
      end else begin
         rsp_s9_in.temperature_centi = temp_s8_ff[TEMP_OUT_W-1:0];
      end
      if (press < PRESS_LOW) begin
         rsp_s9_in.pressure_pa = PRESS_OUT_W'(PRESS_LOW);
         rsp_s9_in.clamped     = 1'b1;
      end else if (press > PRESS_HIGH) begin
         rsp_s9_in.pressure_pa = PRESS_OUT_W'(PRESS_HIGH);
         rsp_s9_in.clamped     = 1'b1;
      end else begin
         rsp_s9_in.pressure_pa = press[PRESS_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         temp_s7_ff <= temp_s7_in;
         off_s7_ff  <= off_s7_in;
         pplo_s7_ff <= pplo_s7_in;
         pphi_s7_ff <= pphi_s7_in;
      end
      if (ctl.load[1]) begin
         temp_s8_ff <= temp_s8_in;
         diff_s8_ff <= diff_s8_in;
      end
      if (ctl.load[2]) begin
         rsp_s9_ff <= rsp_s9_in;
      end
   end

   assign rsp_data = rsp_s9_ff;

endmodule

`default_nettype wire

// File: test/tb_baro_pressure_temp_compensation_core.sv
// Self-checking testbench for the barometric pressure and temperature compensation core.
module tb_baro_pressure_temp_compensation_core;
   timeunit 1ns;
   timeprecision 1ps;

   import baro_ptc_pkg::*;

   localparam int     RESET_CYCLES    = 12;
   localparam int     WATCHDOG_LIMIT  = 2000;
   localparam int     RSP_HOLD_CYCLES = 300;
   localparam int     RANDOM_PHASES   = 10;
   localparam int     PHASE_ITEMS     = 110;
   localparam int     MAX_REPORTS     = 10;
   localparam longint RAW_MAX         = (longint'(1) << RAW_W) - 1;

   localparam calib_type TYPICAL_CALIB = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                           c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CAL_W-1:0]     csr_data = '0;

   calib_type   calib_model = '0;
   rsp_type     expected_readings[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   bit          sender_idle_on = 1'b0;
   bit          receiver_idle_on = 1'b0;
   int          rsp_hold_req = 0;
   int          rsp_hold_ack = 0;
   int          rsp_hold_left = 0;
   int          rsp_stall_left = 0;

   baro_pressure_temp_compensation_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type compensate(input req_type item, input calib_type cal);
      longint  d1, dt, temp, off, sens, t2, off2, sens2, a, b, press;
      logic    clip;
      rsp_type res;
      d1 = longint'(item.raw_pressure);
      dt = longint'(item.raw_temperature) - longint'(cal.c5) * 256;
      temp = TEMP_REF + ((dt * longint'(cal.c6)) >>> 23);
      off = longint'(cal.c2) * 65536 + ((longint'(cal.c4) * dt) >>> 7);
      sens = longint'(cal.c1) * 32768 + ((longint'(cal.c3) * dt) >>> 8);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      // Both the cold and the very cold tests look at the first-order temperature.
      if (temp < TEMP_REF) begin
         a = (temp - TEMP_REF) * (temp - TEMP_REF);
         t2 = (dt * dt) >>> 31;
         off2 = (5 * a) >>> 1;
         sens2 = (5 * a) >>> 2;
         if (temp < TEMP_REF - COLD_OFFSET) begin
            b = (temp - TEMP_REF + COLD_OFFSET) * (temp - TEMP_REF + COLD_OFFSET);
            off2 += 7 * b;
            sens2 += (11 * b) >>> 1;
         end
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
      press = (((d1 * sens) >>> 21) - off) >>> 15;
      clip = 1'b0;
      if (temp < TEMP_LOW) begin
         temp = TEMP_LOW;
         clip = 1'b1;
      end
      if (temp > TEMP_HIGH) begin
         temp = TEMP_HIGH;
         clip = 1'b1;
      end
      if (press < PRESS_LOW) begin
         press = PRESS_LOW;
         clip = 1'b1;
      end
      if (press > PRESS_HIGH) begin
         press = PRESS_HIGH;
         clip = 1'b1;
      end
      res.temperature_centi = TEMP_OUT_W'(temp);
      res.pressure_pa = PRESS_OUT_W'(press);
      res.clamped = clip;
      return res;
   endfunction

   function automatic int unsigned pick_gap_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw_temperature(input calib_type cal);
      longint      v;
      int unsigned span;
      case ($urandom_range(0, 3))
         0: return RAW_W'($urandom());
         1: span = 1 << 16;
         2: span = 1 << 20;
         default: span = 1 << 22;
      endcase
      v = longint'(cal.c5) * 256 + longint'($urandom_range(0, 2 * span)) - longint'(span);
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_W'(v);
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw_pressure();
      if ($urandom_range(0, 3) == 0) return RAW_W'($urandom());
      return RAW_W'($urandom_range(4000000, 13000000));
   endfunction

   function automatic calib_type random_calib();
      calib_type c;
      if ($urandom_range(0, 1) == 0) return calib_type'({$urandom(), $urandom(), $urandom()});
      c.c1 = CAL_W'(TYPICAL_CALIB.c1 + $urandom_range(0, 8191) - 4096);
      c.c2 = CAL_W'(TYPICAL_CALIB.c2 + $urandom_range(0, 8191) - 4096);
      c.c3 = CAL_W'(TYPICAL_CALIB.c3 + $urandom_range(0, 8191) - 4096);
      c.c4 = CAL_W'(TYPICAL_CALIB.c4 + $urandom_range(0, 8191) - 4096);
      c.c5 = CAL_W'(TYPICAL_CALIB.c5 + $urandom_range(0, 8191) - 4096);
      c.c6 = CAL_W'(TYPICAL_CALIB.c6 + $urandom_range(0, 8191) - 4096);
      return c;
   endfunction

   task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      req_type     item;
      int unsigned gap;
      item.raw_pressure = d1;
      item.raw_temperature = d2;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 3) == 0) gap = pick_gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(compensate(item, calib_model));
      @(negedge clock);
   endtask

   task automatic send_random_sample();
      send_sample(pick_raw_pressure(), pick_raw_temperature(calib_model));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (2 * STAGES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_C1: calib_model.c1 = val;
         CSR_C2: calib_model.c2 = val;
         CSR_C3: calib_model.c3 = val;
         CSR_C4: calib_model.c4 = val;
         CSR_C5: calib_model.c5 = val;
         CSR_C6: calib_model.c6 = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_unused_index(input logic [CAL_W-1:0] val);
      write_csr(CSR_IDX_W'($urandom_range(CSR_C6 + 1, (1 << CSR_IDX_W) - 1)), val);
   endtask

   task automatic load_calib(input calib_type c);
      drain_pipeline();
      write_csr(CSR_C1, c.c1);
      write_csr(CSR_C2, c.c2);
      write_csr(CSR_C3, c.c3);
      write_csr(CSR_C4, c.c4);
      write_csr(CSR_C5, c.c5);
      write_csr(CSR_C6, c.c6);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_sample('0, '0);
      send_sample('1, '1);
   endtask

   task automatic test_first_order();
      logic [RAW_W-1:0] ref_raw;
      load_calib(TYPICAL_CALIB);
      ref_raw = RAW_W'(longint'(calib_model.c5) * 256);
      send_sample(24'd9085466, 24'd8569150);
      send_sample(24'd9085466, ref_raw);
      send_sample(24'd9085466, ref_raw - 1);
      send_sample('0, 24'd8569150);
      send_sample('1, 24'd8569150);
   endtask

   task automatic test_cold_correction();
      logic [RAW_W-1:0] ref_raw;
      ref_raw = RAW_W'(longint'(calib_model.c5) * 256);
      send_sample(24'd9085466, ref_raw - 1000000);
      // These two land the first-order temperature on -15.00 C and just below it.
      send_sample(24'd9085466, ref_raw - 1037020);
      send_sample(24'd9085466, ref_raw - 1037021);
      send_sample(24'd9085466, ref_raw - 2500000);
      send_sample(24'd9085466, '0);
      send_sample(24'd9085466, '1);
   endtask

   task automatic test_calib_extremes();
      load_calib('1);
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample('1, '0);
      load_calib('0);
      send_sample('1, '1);
   endtask

   task automatic test_unused_index();
      load_calib(TYPICAL_CALIB);
      @(negedge clock);
      write_csr(CSR_IDX_W'(CSR_C6 + 1), '1);
      write_csr('1, '1);
      csr_valid <= 1'b0;
      send_sample(24'd9085466, 24'd8569150);
      send_sample(24'd6000000, 24'd7000000);
   endtask

   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      rsp_hold_req++;
      repeat (40) send_random_sample();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_calib(random_calib());
         if ($urandom_range(0, 2) == 0) begin
            @(negedge clock);
            write_unused_index(CAL_W'($urandom()));
            csr_valid <= 1'b0;
         end
         sender_idle_on = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) send_random_sample();
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_req != rsp_hold_ack) begin
         rsp_hold_ack = rsp_hold_req;
         rsp_hold_left = RSP_HOLD_CYCLES;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = pick_gap_len() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: temp %0d press %0d clamped %0b",
                        rsp_data.temperature_centi, rsp_data.pressure_pa, rsp_data.clamped);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_data.temperature_centi !== want.temperature_centi ||
                rsp_data.pressure_pa !== want.pressure_pa ||
                rsp_data.clamped !== want.clamped) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected temp %0d press %0d clamped %0b, got %0d %0d %0b",
                           want.temperature_centi, want.pressure_pa, want.clamped,
                           rsp_data.temperature_centi, rsp_data.pressure_pa, rsp_data.clamped);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      receiver_idle_on = 1'b1;
      test_reset_state();
      test_first_order();
      test_cold_correction();
      test_calib_extremes();
      test_unused_index();
      test_backpressure();
      test_random_traffic();
      drain_pipeline();
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
